### hw/rtl/rcfm_pkg.sv
// Shared types and constants of the region chunk filter and merge block.
package rcfm_pkg;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_MERGED    = 2'd0,
        ST_ORDER_ERR = 2'd1,
        ST_EMPTY     = 2'd2
    } t_status;

    typedef struct packed {
        t_status status;
        logic    last;
    } t_res_tag;

    typedef struct packed {
        logic one;
        logic two;
    } t_push;

endpackage

### hw/rtl/rcfm_front.sv
// Front part: stop filter, order check, open chunk merge and result generation.
module rcfm_front #(
    parameter int OFFSET_BITS = 64,
    parameter int BLOCK_SHIFT = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [OFFSET_BITS-1:0] i_cfg_data,
    input  logic                   i_accept,
    input  logic [OFFSET_BITS-1:0] i_chunk_start,
    input  logic [OFFSET_BITS-1:0] i_chunk_stop,
    input  logic                   i_last_chunk,
    output rcfm_pkg::t_push        o_push,
    output logic [OFFSET_BITS-1:0] o_res0_start,
    output logic [OFFSET_BITS-1:0] o_res0_stop,
    output rcfm_pkg::t_res_tag     o_res0_tag,
    output logic [OFFSET_BITS-1:0] o_res1_start,
    output logic [OFFSET_BITS-1:0] o_res1_stop,
    output rcfm_pkg::t_res_tag     o_res1_tag
);
    import rcfm_pkg::*;

    logic [OFFSET_BITS-1:0] r_min_offset;
    logic [OFFSET_BITS-1:0] r_open_start, n_open_start;
    logic [OFFSET_BITS-1:0] r_open_stop, n_open_stop;
    logic                   r_open_valid, n_open_valid;
    logic [OFFSET_BITS-1:0] r_last_kept, n_last_kept;
    logic                   r_any_kept, n_any_kept;
    logic                   r_discarding, n_discarding;

    logic keep;
    logic order_err;
    logic covered;
    logic same_block;
    logic emit_open;
    logic emit_flush;

    always_comb begin
        keep       = (i_chunk_stop >= r_min_offset);
        order_err  = keep && r_any_kept && (i_chunk_start <= r_last_kept);
        covered    = (i_chunk_stop < r_open_stop);
        same_block = ((i_chunk_start >> BLOCK_SHIFT) <= (r_open_stop >> BLOCK_SHIFT));

        n_open_start = r_open_start;
        n_open_stop  = r_open_stop;
        n_open_valid = r_open_valid;
        n_last_kept  = r_last_kept;
        n_any_kept   = r_any_kept;
        n_discarding = r_discarding;
        emit_open    = 1'b0;
        emit_flush   = 1'b0;
        o_push       = '0;
        o_res0_start = '0;
        o_res0_stop  = '0;
        o_res0_tag   = '{status: ST_MERGED, last: 1'b0};
        o_res1_start = '0;
        o_res1_stop  = '0;
        o_res1_tag   = '{status: ST_MERGED, last: 1'b1};

        if (i_accept) begin
            if (r_discarding) begin
                if (i_last_chunk) begin
                    n_discarding = 1'b0;
                end
            end else if (order_err) begin
                o_push.one   = 1'b1;
                o_res0_tag   = '{status: ST_ORDER_ERR, last: 1'b1};
                n_open_start = '0;
                n_open_stop  = '0;
                n_open_valid = 1'b0;
                n_last_kept  = '0;
                n_any_kept   = 1'b0;
                n_discarding = !i_last_chunk;
            end else begin
                if (keep) begin
                    n_any_kept  = 1'b1;
                    n_last_kept = i_chunk_start;
                    if (!r_open_valid) begin
                        n_open_start = i_chunk_start;
                        n_open_stop  = i_chunk_stop;
                        n_open_valid = 1'b1;
                    end else if (covered) begin
                        n_open_stop = r_open_stop;
                    end else if (same_block) begin
                        n_open_stop = i_chunk_stop;
                    end else begin
                        emit_open    = 1'b1;
                        n_open_start = i_chunk_start;
                        n_open_stop  = i_chunk_stop;
                    end
                end
                emit_flush = i_last_chunk;

                // flush result carries the updated open chunk or an empty marker
                o_res1_start = n_open_valid ? n_open_start : '0;
                o_res1_stop  = n_open_valid ? n_open_stop : '0;
                o_res1_tag   = '{status: (n_open_valid ? ST_MERGED : ST_EMPTY),
                                 last: 1'b1};

                o_push.one = emit_open || emit_flush;
                o_push.two = emit_open && emit_flush;
                if (emit_open) begin
                    o_res0_start = r_open_start;
                    o_res0_stop  = r_open_stop;
                    o_res0_tag   = '{status: ST_MERGED, last: 1'b0};
                end else begin
                    o_res0_start = o_res1_start;
                    o_res0_stop  = o_res1_stop;
                    o_res0_tag   = o_res1_tag;
                end

                if (i_last_chunk) begin
                    n_open_start = '0;
                    n_open_stop  = '0;
                    n_open_valid = 1'b0;
                    n_last_kept  = '0;
                    n_any_kept   = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_offset <= '0;
            r_open_start <= '0;
            r_open_stop  <= '0;
            r_open_valid <= 1'b0;
            r_last_kept  <= '0;
            r_any_kept   <= 1'b0;
            r_discarding <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_offset <= i_cfg_data;
            end
            r_open_start <= n_open_start;
            r_open_stop  <= n_open_stop;
            r_open_valid <= n_open_valid;
            r_last_kept  <= n_last_kept;
            r_any_kept   <= n_any_kept;
            r_discarding <= n_discarding;
        end
    end

endmodule

### hw/rtl/rcfm_queue.sv
// Result queue between front and back: two pushes and one pop per cycle.
module rcfm_queue #(
    parameter int OFFSET_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rcfm_pkg::t_push              i_push,
    input  logic [OFFSET_BITS-1:0]       i_res0_start,
    input  logic [OFFSET_BITS-1:0]       i_res0_stop,
    input  rcfm_pkg::t_res_tag           i_res0_tag,
    input  logic [OFFSET_BITS-1:0]       i_res1_start,
    input  logic [OFFSET_BITS-1:0]       i_res1_stop,
    input  rcfm_pkg::t_res_tag           i_res1_tag,
    input  logic                         i_pop,
    output logic                         o_nonempty,
    output logic [OFFSET_BITS-1:0]       o_head_start,
    output logic [OFFSET_BITS-1:0]       o_head_stop,
    output rcfm_pkg::t_res_tag           o_head_tag,
    output logic [rcfm_pkg::Q_CNT_W-1:0] o_count
);
    import rcfm_pkg::*;

    logic [OFFSET_BITS-1:0] r_start [Q_DEPTH];
    logic [OFFSET_BITS-1:0] r_stop  [Q_DEPTH];
    t_res_tag               r_tag   [Q_DEPTH];
    logic [Q_PTR_W-1:0]     r_wptr, n_wptr;
    logic [Q_PTR_W-1:0]     r_rptr, n_rptr;
    logic [Q_CNT_W-1:0]     r_count, n_count;
    logic [Q_PTR_W-1:0]     wptr1;
    logic                   pop_ok;

    always_comb begin
        wptr1   = r_wptr + Q_PTR_W'(1);
        pop_ok  = i_pop && (r_count != '0);
        n_wptr  = r_wptr + Q_PTR_W'(i_push.one) + Q_PTR_W'(i_push.two);
        n_rptr  = r_rptr + Q_PTR_W'(pop_ok);
        n_count = r_count + Q_CNT_W'(i_push.one) + Q_CNT_W'(i_push.two)
                  - Q_CNT_W'(pop_ok);
    end

    assign o_nonempty   = (r_count != '0);
    assign o_head_start = r_start[r_rptr];
    assign o_head_stop  = r_stop[r_rptr];
    assign o_head_tag   = r_tag[r_rptr];
    assign o_count      = r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.one) begin
            r_start[r_wptr] <= i_res0_start;
            r_stop[r_wptr]  <= i_res0_stop;
            r_tag[r_wptr]   <= i_res0_tag;
        end
        if (i_push.two) begin
            r_start[wptr1] <= i_res1_start;
            r_stop[wptr1]  <= i_res1_stop;
            r_tag[wptr1]   <= i_res1_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

### hw/rtl/rcfm_back.sv
// Back part: output register that drains the result queue under stall.
module rcfm_back #(
    parameter int OFFSET_BITS = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_nonempty,
    input  logic [OFFSET_BITS-1:0] i_head_start,
    input  logic [OFFSET_BITS-1:0] i_head_stop,
    input  rcfm_pkg::t_res_tag     i_head_tag,
    output logic                   o_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [OFFSET_BITS-1:0] o_merged_start,
    output logic [OFFSET_BITS-1:0] o_merged_stop,
    output logic [1:0]             o_status,
    output logic                   o_last_of_run
);
    import rcfm_pkg::*;

    logic                   r_valid;
    logic [OFFSET_BITS-1:0] r_start;
    logic [OFFSET_BITS-1:0] r_stop;
    t_res_tag               r_tag;

    assign o_pop          = i_nonempty && (!r_valid || !i_out_stall);
    assign o_out_valid    = r_valid;
    assign o_merged_start = r_start;
    assign o_merged_stop  = r_stop;
    assign o_status       = r_tag.status;
    assign o_last_of_run  = r_tag.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || !i_out_stall) begin
            r_valid <= i_nonempty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_start <= i_head_start;
            r_stop  <= i_head_stop;
            r_tag   <= i_head_tag;
        end
    end

endmodule

### hw/rtl/region_chunk_filter_merge_top.sv
// Top level of the region chunk filter and merge block.
//
//  channel  direction  handshake                payload
//  cfg      in         i_cfg_we                 i_cfg_data (min_offset)
//  in       in         i_in_valid / o_in_stall  i_chunk_start, i_chunk_stop, i_last_chunk
//  out      out        o_out_valid / i_out_stall o_merged_start, o_merged_stop,
//                                               o_status, o_last_of_run
//
// One chunk is taken per cycle while o_in_stall is low; its merge decision settles
// in the same cycle. Results pass through a four-entry queue into the output
// register; the output delivers one result per cycle while i_out_stall is low.
// o_in_stall rises when fewer than two queue entries are free.
// Synchronous active-low reset clears the open chunk, queue and min_offset.
module region_chunk_filter_merge_top #(
    parameter int OFFSET_BITS = 64,
    parameter int BLOCK_SHIFT = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [OFFSET_BITS-1:0] i_cfg_data,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [OFFSET_BITS-1:0] i_chunk_start,
    input  logic [OFFSET_BITS-1:0] i_chunk_stop,
    input  logic                   i_last_chunk,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [OFFSET_BITS-1:0] o_merged_start,
    output logic [OFFSET_BITS-1:0] o_merged_stop,
    output logic [1:0]             o_status,
    output logic                   o_last_of_run
);
    import rcfm_pkg::*;

    logic                   accept;
    t_push                  push;
    logic [OFFSET_BITS-1:0] res0_start, res0_stop, res1_start, res1_stop;
    t_res_tag               res0_tag, res1_tag;
    logic                   pop;
    logic                   nonempty;
    logic [OFFSET_BITS-1:0] head_start, head_stop;
    t_res_tag               head_tag;
    logic [Q_CNT_W-1:0]     q_count;

    assign o_in_stall = (q_count > Q_CNT_W'(Q_DEPTH - 2));
    assign accept     = i_in_valid && !o_in_stall;

    rcfm_front #(
        .OFFSET_BITS(OFFSET_BITS),
        .BLOCK_SHIFT(BLOCK_SHIFT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_chunk_start(i_chunk_start),
        .i_chunk_stop (i_chunk_stop),
        .i_last_chunk (i_last_chunk),
        .o_push       (push),
        .o_res0_start (res0_start),
        .o_res0_stop  (res0_stop),
        .o_res0_tag   (res0_tag),
        .o_res1_start (res1_start),
        .o_res1_stop  (res1_stop),
        .o_res1_tag   (res1_tag)
    );

    rcfm_queue #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res0_start(res0_start),
        .i_res0_stop (res0_stop),
        .i_res0_tag  (res0_tag),
        .i_res1_start(res1_start),
        .i_res1_stop (res1_stop),
        .i_res1_tag  (res1_tag),
        .i_pop       (pop),
        .o_nonempty  (nonempty),
        .o_head_start(head_start),
        .o_head_stop (head_stop),
        .o_head_tag  (head_tag),
        .o_count     (q_count)
    );

    rcfm_back #(
        .OFFSET_BITS(OFFSET_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_nonempty    (nonempty),
        .i_head_start  (head_start),
        .i_head_stop   (head_stop),
        .i_head_tag    (head_tag),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_merged_start(o_merged_start),
        .o_merged_stop (o_merged_stop),
        .o_status      (o_status),
        .o_last_of_run (o_last_of_run)
    );

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (q_count <= Q_CNT_W'(Q_DEPTH - 2)))
        else $error("transfer accepted without room for two results");

    a_push_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.two |-> push.one)
        else $error("second result pushed without the first");

    a_flag_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_MERGED)) |->
        ((o_merged_start == '0) && (o_merged_stop == '0) && o_last_of_run))
        else $error("error or empty result with nonzero payload");

endmodule
